>>> hdl/lsam_pkg.sv
// Shared types, codes and helpers for the limit switch arm motion controller.
// Used by the channel interfaces, the pass logic and the top level.
`default_nettype none

package lsam_pkg;

    // Arm modes, also the arm_mode output code.
    localparam logic [2:0] MODE_STOPPED = 3'd0;
    localparam logic [2:0] MODE_IN      = 3'd1;
    localparam logic [2:0] MODE_OUT     = 3'd2;
    localparam logic [2:0] MODE_CLOSED  = 3'd3;
    localparam logic [2:0] MODE_OPEN    = 3'd4;
    localparam logic [2:0] MODE_ERROR   = 3'd5;

    // Pending serial command.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_IN   = 2'd1;
    localparam logic [1:0] PEND_OUT  = 2'd2;
    localparam logic [1:0] PEND_STOP = 2'd3;

    // Command characters.
    localparam logic [7:0] CH_IN_LO   = 8'h69;
    localparam logic [7:0] CH_IN_UP   = 8'h49;
    localparam logic [7:0] CH_OUT_LO  = 8'h6F;
    localparam logic [7:0] CH_OUT_UP  = 8'h4F;
    localparam logic [7:0] CH_STOP_LO = 8'h73;
    localparam logic [7:0] CH_STOP_UP = 8'h53;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_HOLDOFF = 2'd0;
    localparam logic [1:0]  CFG_EXTEND  = 2'd1;
    localparam logic [1:0]  CFG_BLINK   = 2'd2;
    localparam logic [15:0] HOLDOFF_RST = 16'd1000;
    localparam logic [15:0] EXTEND_RST  = 16'd1000;
    localparam logic [15:0] BLINK_RST   = 16'd200;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        byte_valid;
        logic [7:0]  rx_byte;
        logic        limit_inner;
        logic        limit_outer;
        logic        outward_button;
        logic        inward_button;
    } t_in_word;

    typedef struct packed {
        logic [2:0] arm_mode;
        logic       drive_inward;
        logic       drive_outward;
        logic       lamp_inner;
        logic       lamp_outer;
    } t_out_word;

    typedef struct packed {
        logic [15:0] button_holdoff_ms;
        logic [15:0] inward_extend_ms;
        logic [15:0] blink_period_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  pending;
        logic [31:0] button_deadline;
        logic [31:0] extend_deadline;
        logic [31:0] blink_deadline;
        logic        blink_phase;
        logic        drv_in;
        logic        drv_out;
        logic        lamp_in;
        logic        lamp_out;
    } t_state;

    // True when a is later than b on the wrapping millisecond clock.
    function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

`default_nettype wire

>>> hdl/lsam_if.sv
// Valid/ready channel interfaces for control pass words and result words.
// Depends on lsam_pkg for the payload types.
`default_nettype none

interface lsam_in_if;
    logic               valid;
    logic               ready;
    lsam_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lsam_out_if;
    logic                valid;
    logic                ready;
    lsam_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/lsam_pass.sv
// Combinational logic of one control pass: command decode, request arbitration,
// mode step and lamp blink. Depends on lsam_pkg.
`default_nettype none

module lsam_pass (
    input  wire lsam_pkg::t_in_word  i_word,
    input  wire lsam_pkg::t_cfg      i_cfg,
    input  wire lsam_pkg::t_state    i_state,
    output lsam_pkg::t_state         o_state,
    output lsam_pkg::t_out_word      o_result
);

    logic        btn_ok;
    logic        req_in;
    logic        req_out;
    logic        li;
    logic        lo;
    logic        lit;
    logic [1:0]  pend;
    lsam_pkg::t_state s;

    assign li     = i_word.limit_inner;
    assign lo     = i_word.limit_outer;
    assign btn_ok = lsam_pkg::is_later(i_word.now_ms, i_state.button_deadline);

    always_comb begin
        s       = i_state;
        req_in  = 1'b0;
        req_out = 1'b0;
        lit     = 1'b0;
        pend    = i_state.pending;

        if (i_word.byte_valid) begin
            if (i_word.rx_byte inside {lsam_pkg::CH_IN_LO, lsam_pkg::CH_IN_UP}) begin
                pend = lsam_pkg::PEND_IN;
            end else if (i_word.rx_byte inside
                         {lsam_pkg::CH_OUT_LO, lsam_pkg::CH_OUT_UP}) begin
                pend = lsam_pkg::PEND_OUT;
            end else if (i_word.rx_byte inside
                         {lsam_pkg::CH_STOP_LO, lsam_pkg::CH_STOP_UP}) begin
                pend = lsam_pkg::PEND_STOP;
            end
        end

        // Priority: serial outward, outward button, serial inward, inward button.
        if (pend == lsam_pkg::PEND_OUT) begin
            pend    = lsam_pkg::PEND_NONE;
            req_out = 1'b1;
        end else if (btn_ok && i_word.outward_button) begin
            s.button_deadline = i_word.now_ms + {16'd0, i_cfg.button_holdoff_ms};
            req_out = 1'b1;
        end else if (pend == lsam_pkg::PEND_IN) begin
            pend   = lsam_pkg::PEND_NONE;
            req_in = 1'b1;
        end else if (btn_ok && i_word.inward_button) begin
            s.button_deadline = i_word.now_ms + {16'd0, i_cfg.button_holdoff_ms};
            req_in = 1'b1;
        end
        if (pend == lsam_pkg::PEND_STOP) begin
            pend = lsam_pkg::PEND_NONE;
        end
        s.pending = pend;

        if (li && lo) begin
            s.mode = lsam_pkg::MODE_ERROR;
        end

        case (s.mode)
            lsam_pkg::MODE_STOPPED: begin
                s.drv_in   = 1'b0;
                s.drv_out  = 1'b0;
                s.lamp_in  = 1'b0;
                s.lamp_out = 1'b0;
                if (li && !lo) begin
                    s.mode = lsam_pkg::MODE_CLOSED;
                end else if (!li && lo) begin
                    s.mode = lsam_pkg::MODE_OPEN;
                end else if (req_in && !li) begin
                    s.mode = lsam_pkg::MODE_IN;
                end else if (req_out && !lo) begin
                    s.mode = lsam_pkg::MODE_OUT;
                end
            end
            lsam_pkg::MODE_IN: begin
                s.drv_in   = 1'b1;
                s.drv_out  = 1'b0;
                s.lamp_in  = 1'b1;
                s.lamp_out = 1'b0;
                if (li) begin
                    s.extend_deadline = i_word.now_ms + {16'd0, i_cfg.inward_extend_ms};
                    s.mode = lsam_pkg::MODE_CLOSED;
                end else if (req_in || req_out) begin
                    s.mode = lsam_pkg::MODE_STOPPED;
                end
            end
            lsam_pkg::MODE_OUT: begin
                s.drv_in   = 1'b0;
                s.drv_out  = 1'b1;
                s.lamp_in  = 1'b0;
                s.lamp_out = 1'b1;
                // A request in the same pass wins over reaching the outer limit.
                if (req_in || req_out) begin
                    s.mode = lsam_pkg::MODE_STOPPED;
                end else if (lo) begin
                    s.mode = lsam_pkg::MODE_OPEN;
                end
            end
            lsam_pkg::MODE_CLOSED: begin
                if (lsam_pkg::is_later(i_word.now_ms, i_state.extend_deadline)) begin
                    s.drv_in  = 1'b0;
                    s.drv_out = 1'b0;
                end
                if (req_out) begin
                    s.mode = lsam_pkg::MODE_OUT;
                end
            end
            lsam_pkg::MODE_OPEN: begin
                s.drv_in  = 1'b0;
                s.drv_out = 1'b0;
                if (req_in) begin
                    s.mode = lsam_pkg::MODE_IN;
                end
            end
            lsam_pkg::MODE_ERROR: begin
                s.drv_in  = 1'b0;
                s.drv_out = 1'b0;
                if (li && !lo) begin
                    s.mode = lsam_pkg::MODE_CLOSED;
                end else if (!li && lo) begin
                    s.mode = lsam_pkg::MODE_OPEN;
                end else if (!li && !lo) begin
                    s.mode = lsam_pkg::MODE_STOPPED;
                end
            end
            default: begin
                s.mode = lsam_pkg::MODE_STOPPED;
            end
        endcase

        if (lsam_pkg::is_later(i_word.now_ms, i_state.blink_deadline)) begin
            s.blink_deadline = i_word.now_ms + {16'd0, i_cfg.blink_period_ms};
            s.blink_phase    = !i_state.blink_phase;
            lit              = i_state.blink_phase;
            if (s.mode == lsam_pkg::MODE_CLOSED) begin
                s.lamp_in  = lit;
                s.lamp_out = 1'b0;
            end else if (s.mode == lsam_pkg::MODE_OPEN) begin
                s.lamp_in  = 1'b0;
                s.lamp_out = lit;
            end else if (s.mode == lsam_pkg::MODE_ERROR) begin
                s.lamp_in  = lit;
                s.lamp_out = lit;
            end
        end
    end

    assign o_state                = s;
    assign o_result.arm_mode      = s.mode;
    assign o_result.drive_inward  = s.drv_in;
    assign o_result.drive_outward = s.drv_out;
    assign o_result.lamp_inner    = s.lamp_in;
    assign o_result.lamp_outer    = s.lamp_out;

endmodule

`default_nettype wire

>>> hdl/limit_switch_arm_motion_controller.sv
// Limit switch arm motion controller.
// Channels: i_in takes one control pass word (time, optional command byte,
// limit sensors, buttons); o_out gives one result word (mode, relays, lamps)
// for every pass word, in order. Both use valid/ready; a word moves at a clock
// edge where both are high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 button hold-off, 1 inward extension, 2 blink half period, all in ms).
// Writes are meant for idle periods; other indexes are ignored.
// A word accepted on i_in waits in the input register, and the pass logic
// between it and the result register gives the result that is loaded there.
// Throughput: one word per clock while o_out is not stalled. The controller
// state updates at the same edge that loads the result, so the next word sees
// it at once.
// Reset (synchronous, active low) returns the state to stopped with relays and
// lamps off, deadlines at zero, and the registers to their defaults.
// When the receiver stalls, the result register holds its word and the input
// register fills; i_in.ready then drops until o_out.ready returns.
// Depends on lsam_pkg, lsam_if and lsam_pass.
`default_nettype none

module limit_switch_arm_motion_controller (
    input  wire               i_clk,
    input  wire               i_rst_n,
    lsam_in_if.sink           i_in,
    lsam_out_if.source        o_out,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_idx,
    input  wire  [15:0]       i_cfg_data
);

    logic                r_in_valid;
    lsam_pkg::t_in_word  r_in;
    logic                r_out_valid;
    lsam_pkg::t_out_word r_out;
    lsam_pkg::t_state    r_state;
    lsam_pkg::t_state    n_state;
    lsam_pkg::t_cfg      r_cfg;
    lsam_pkg::t_out_word n_out;
    logic                advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    lsam_pass u_pass (
        .i_word   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= lsam_pkg::MODE_STOPPED;
            r_state.pending         <= lsam_pkg::PEND_NONE;
            r_state.button_deadline <= 32'd0;
            r_state.extend_deadline <= 32'd0;
            r_state.blink_deadline  <= 32'd0;
            r_state.blink_phase     <= 1'b0;
            r_state.drv_in          <= 1'b0;
            r_state.drv_out         <= 1'b0;
            r_state.lamp_in         <= 1'b0;
            r_state.lamp_out        <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_holdoff_ms <= lsam_pkg::HOLDOFF_RST;
            r_cfg.inward_extend_ms  <= lsam_pkg::EXTEND_RST;
            r_cfg.blink_period_ms   <= lsam_pkg::BLINK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsam_pkg::CFG_HOLDOFF: r_cfg.button_holdoff_ms <= i_cfg_data;
                lsam_pkg::CFG_EXTEND:  r_cfg.inward_extend_ms  <= i_cfg_data;
                lsam_pkg::CFG_BLINK:   r_cfg.blink_period_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> bench/lsam_motion_checker.sv
// Checker for the limit switch arm motion controller: watches the pass and result
// channels and the register port, predicts each result word and compares it.
// Depends on lsam_pkg and the channel interfaces in lsam_if.
module lsam_motion_checker
    import lsam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsam_in_if          i_pass,
    lsam_out_if         i_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    logic [15:0] holdoff_ms;
    logic [15:0] extend_ms;
    logic [15:0] blink_ms;

    // Controller state as the predictor sees it.
    logic [2:0]  mode_now;
    logic [1:0]  queued_cmd;
    logic [31:0] button_until;
    logic [31:0] extend_until;
    logic [31:0] blink_until;
    logic        blink_toggle;
    logic        drv_in_on;
    logic        drv_out_on;
    logic        lamp_in_on;
    logic        lamp_out_on;

    t_out_word predicted_results[$];
    int        fails = 0;
    int        waiting_cnt = 0;

    assign o_fail_count = fails;
    assign o_waiting    = waiting_cnt;

    // Wrapping compare: a lies in the half range after b.
    function automatic logic time_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return (diff != 32'd0) && (diff < 32'h8000_0000);
    endfunction

    task automatic predict_pass(input t_in_word w, output t_out_word r);
        logic want_in;
        logic want_out;
        logic lit;
        want_in  = 1'b0;
        want_out = 1'b0;
        if (w.byte_valid) begin
            case (w.rx_byte)
                CH_IN_LO, CH_IN_UP:     queued_cmd = PEND_IN;
                CH_OUT_LO, CH_OUT_UP:   queued_cmd = PEND_OUT;
                CH_STOP_LO, CH_STOP_UP: queued_cmd = PEND_STOP;
                default: ;
            endcase
        end

        // One request per pass; a queued outward command beats the buttons.
        if (queued_cmd == PEND_OUT) begin
            queued_cmd = PEND_NONE;
            want_out   = 1'b1;
        end else if (time_after(w.now_ms, button_until) && w.outward_button) begin
            button_until = w.now_ms + {16'd0, holdoff_ms};
            want_out     = 1'b1;
        end else if (queued_cmd == PEND_IN) begin
            queued_cmd = PEND_NONE;
            want_in    = 1'b1;
        end else if (time_after(w.now_ms, button_until) && w.inward_button) begin
            button_until = w.now_ms + {16'd0, holdoff_ms};
            want_in      = 1'b1;
        end
        if (queued_cmd == PEND_STOP) queued_cmd = PEND_NONE;

        if (w.limit_inner && w.limit_outer) mode_now = MODE_ERROR;

        case (mode_now)
            MODE_STOPPED: begin
                drv_in_on   = 1'b0;
                drv_out_on  = 1'b0;
                lamp_in_on  = 1'b0;
                lamp_out_on = 1'b0;
                if (w.limit_inner && !w.limit_outer) mode_now = MODE_CLOSED;
                else if (!w.limit_inner && w.limit_outer) mode_now = MODE_OPEN;
                else if (want_in && !w.limit_inner) mode_now = MODE_IN;
                else if (want_out && !w.limit_outer) mode_now = MODE_OUT;
            end
            MODE_IN: begin
                drv_in_on   = 1'b1;
                drv_out_on  = 1'b0;
                lamp_in_on  = 1'b1;
                lamp_out_on = 1'b0;
                if (w.limit_inner) begin
                    extend_until = w.now_ms + {16'd0, extend_ms};
                    mode_now     = MODE_CLOSED;
                end else if (want_in || want_out) begin
                    mode_now = MODE_STOPPED;
                end
            end
            MODE_OUT: begin
                drv_in_on   = 1'b0;
                drv_out_on  = 1'b1;
                lamp_in_on  = 1'b0;
                lamp_out_on = 1'b1;
                if (w.limit_outer) mode_now = MODE_OPEN;
                if (want_in || want_out) mode_now = MODE_STOPPED;
            end
            MODE_CLOSED: begin
                // The relays keep their levels until the extension time has run out.
                if (time_after(w.now_ms, extend_until)) begin
                    drv_in_on  = 1'b0;
                    drv_out_on = 1'b0;
                end
                if (want_out) mode_now = MODE_OUT;
            end
            MODE_OPEN: begin
                drv_in_on  = 1'b0;
                drv_out_on = 1'b0;
                if (want_in) mode_now = MODE_IN;
            end
            MODE_ERROR: begin
                drv_in_on  = 1'b0;
                drv_out_on = 1'b0;
                if (w.limit_inner && !w.limit_outer) mode_now = MODE_CLOSED;
                else if (!w.limit_inner && w.limit_outer) mode_now = MODE_OPEN;
                else if (!w.limit_inner && !w.limit_outer) mode_now = MODE_STOPPED;
            end
            default: begin
                mode_now = MODE_STOPPED;
            end
        endcase

        if (time_after(w.now_ms, blink_until)) begin
            blink_until  = w.now_ms + {16'd0, blink_ms};
            blink_toggle = !blink_toggle;
            lit          = !blink_toggle;
            if (mode_now == MODE_CLOSED) begin
                lamp_in_on  = lit;
                lamp_out_on = 1'b0;
            end else if (mode_now == MODE_OPEN) begin
                lamp_in_on  = 1'b0;
                lamp_out_on = lit;
            end else if (mode_now == MODE_ERROR) begin
                lamp_in_on  = lit;
                lamp_out_on = lit;
            end
        end

        r.arm_mode      = mode_now;
        r.drive_inward  = drv_in_on;
        r.drive_outward = drv_out_on;
        r.lamp_inner    = lamp_in_on;
        r.lamp_outer    = lamp_out_on;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            holdoff_ms   = HOLDOFF_RST;
            extend_ms    = EXTEND_RST;
            blink_ms     = BLINK_RST;
            mode_now     = MODE_STOPPED;
            queued_cmd   = PEND_NONE;
            button_until = '0;
            extend_until = '0;
            blink_until  = '0;
            blink_toggle = 1'b0;
            drv_in_on    = 1'b0;
            drv_out_on   = 1'b0;
            lamp_in_on   = 1'b0;
            lamp_out_on  = 1'b0;
            predicted_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HOLDOFF: holdoff_ms = i_cfg_data;
                    CFG_EXTEND:  extend_ms  = i_cfg_data;
                    CFG_BLINK:   blink_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pass.valid && i_pass.ready) begin
                predict_pass(i_pass.data, want);
                predicted_results.push_back(want);
            end
            if (i_result.valid && i_result.ready) begin
                got = i_result.data;
                if (predicted_results.size() == 0) begin
                    $error("result word with no prediction waiting: mode %0d", got.arm_mode);
                    fails++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("arm_mode", want.arm_mode, got.arm_mode);
                    check_field("drive_inward", want.drive_inward, got.drive_inward);
                    check_field("drive_outward", want.drive_outward, got.drive_outward);
                    check_field("lamp_inner", want.lamp_inner, got.lamp_inner);
                    check_field("lamp_outer", want.lamp_outer, got.lamp_outer);
                end
            end
        end
        waiting_cnt = predicted_results.size();
    end

endmodule

>>> bench/limit_switch_arm_motion_controller_tb.sv
// Testbench top for the limit switch arm motion controller: clock, reset, stimulus
// with random idling on both channels, register phases, watchdog and verdict.
// Depends on lsam_pkg, lsam_if, the controller RTL and lsam_motion_checker.
module limit_switch_arm_motion_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsam_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 105;
    localparam int PHASE_COUNT   = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count;
    int          waiting_cnt;
    int          quiet_cycles;
    bit          calm;

    lsam_in_if  pass_ch();
    lsam_out_if result_ch();

    limit_switch_arm_motion_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pass_ch),
        .o_out      (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lsam_motion_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pass       (pass_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_word make_pass(input logic [31:0] t, input logic bv,
                                           input logic [7:0] ch, input logic li,
                                           input logic lo, input logic bo,
                                           input logic bi);
        t_in_word w;
        w.now_ms         = t;
        w.byte_valid     = bv;
        w.rx_byte        = ch;
        w.limit_inner    = li;
        w.limit_outer    = lo;
        w.outward_button = bo;
        w.inward_button  = bi;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            pass_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pass_ch.valid <= 1'b1;
        pass_ch.data  <= w;
        do @(posedge i_clk); while (!pass_ch.ready);
        @(negedge i_clk);
    endtask

    // Registers are only written once every predicted word has come back.
    task automatic settle();
        pass_ch.valid <= 1'b0;
        while (waiting_cnt != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side: a random stall before each word, none while calm is set.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pass_ch.valid && pass_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("limit_switch_arm_motion_controller_tb: FAIL");
        $finish;
    end

    initial begin
        t_in_word    w;
        logic [31:0] clock_ms;
        logic [1:0]  sensor;
        logic [7:0]  cmd_chars[6];
        logic [7:0]  ch;
        logic [15:0] hold_v;
        logic [15:0] ext_v;
        logic [15:0] blink_v;
        logic        bv;
        int          pick;

        cmd_chars = '{CH_IN_LO, CH_IN_UP, CH_OUT_LO, CH_OUT_UP, CH_STOP_LO, CH_STOP_UP};
        pass_ch.valid   = 1'b0;
        pass_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_HOLDOFF;
        cfg_data        = '0;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the modes with the reset register values.
        // Time zero equals every deadline, so nothing counts as later yet.
        send_word(make_pass(32'd0, 1'b0, CH_OUT_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd10, 1'b1, CH_OUT_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd20, 1'b1, CH_OUT_UP, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd30, 1'b1, CH_IN_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd40, 1'b1, CH_IN_UP, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd50, 1'b1, CH_IN_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        // Reaching the inner limit starts the extension time.
        send_word(make_pass(32'd60, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd300, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd1100, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd1110, 1'b1, CH_STOP_LO, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd1120, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd1130, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
        // Button press, then a second press inside the hold-off.
        send_word(make_pass(32'd1200, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        send_word(make_pass(32'd1210, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
        send_word(make_pass(32'd1300, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        // Both limits force error; it leaves by the limit levels.
        send_word(make_pass(32'd1400, 1'b1, CH_STOP_UP, 1'b1, 1'b1, 1'b0, 1'b0));
        send_word(make_pass(32'd1500, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_pass(32'd1800, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd1900, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
        send_word(make_pass(32'd2000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd2300, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
        send_word(make_pass(32'd2310, 1'b1, CH_OUT_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'd2320, 1'b1, CH_OUT_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        // Outer limit and a request in the same word: the request wins.
        send_word(make_pass(32'd2330, 1'b1, CH_IN_LO, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_pass(32'd2340, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_pass(32'd2350, 1'b1, CH_IN_UP, 1'b0, 1'b1, 1'b0, 1'b0));
        // Time wrap, then a jump of exactly half the range, which is not later.
        send_word(make_pass(32'hFFFF_FFF0, 1'b1, CH_OUT_UP, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(make_pass(32'h0000_0010, 1'b1, CH_OUT_LO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_pass(32'h8000_0010, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));

        clock_ms = 32'h8000_0100;
        sensor   = 2'b00;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            case (p)
                0: begin
                    hold_v = HOLDOFF_RST;
                    ext_v = EXTEND_RST;
                    blink_v = BLINK_RST;
                end
                1: begin
                    hold_v = 16'd0;
                    ext_v = 16'd0;
                    blink_v = 16'd0;
                end
                2: begin
                    hold_v = 16'hFFFF;
                    ext_v = 16'hFFFF;
                    blink_v = 16'hFFFF;
                end
                3: begin
                    hold_v = 16'($urandom_range(0, 600));
                    ext_v = 16'($urandom_range(0, 600));
                    blink_v = 16'($urandom_range(0, 600));
                end
                4: begin
                    hold_v = 16'd1;
                    ext_v = 16'd1;
                    blink_v = 16'd1;
                    clock_ms = 32'hFFFF_F000;
                end
                default: begin
                    hold_v = 16'($urandom_range(0, 16'hFFFF));
                    ext_v = 16'($urandom_range(0, 16'hFFFF));
                    blink_v = 16'($urandom_range(0, 16'hFFFF));
                end
            endcase
            write_reg(CFG_HOLDOFF, hold_v);
            write_reg(CFG_EXTEND, ext_v);
            write_reg(CFG_BLINK, blink_v);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);

                pick = $urandom_range(0, 99);
                if (pick < 10) clock_ms = clock_ms;
                else if (pick < 80) clock_ms = clock_ms + $urandom_range(1, 250);
                else if (pick < 95) clock_ms = clock_ms + $urandom_range(251, 3000);
                else clock_ms = clock_ms + $urandom;

                // Sensors follow a slowly changing arm position, with some noise.
                if ($urandom_range(0, 99) < 8) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) sensor = 2'b00;
                    else if (pick < 68) sensor = 2'b01;
                    else if (pick < 96) sensor = 2'b10;
                    else sensor = 2'b11;
                end

                bv = ($urandom_range(0, 99) < 30);
                if (bv && $urandom_range(0, 4) != 0) ch = cmd_chars[3'($urandom_range(0, 5))];
                else ch = 8'($urandom_range(0, 255));

                w = make_pass(clock_ms, bv, ch, sensor[0], sensor[1],
                              $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12);
                if ($urandom_range(0, 99) < 5) begin
                    w.limit_inner = 1'($urandom_range(0, 1));
                    w.limit_outer = 1'($urandom_range(0, 1));
                end
                send_word(w);
            end
        end

        calm = 1'b0;
        settle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && waiting_cnt == 0)
            $display("limit_switch_arm_motion_controller_tb: PASS");
        else
            $display("limit_switch_arm_motion_controller_tb: FAIL");
        $finish;
    end

endmodule
